// ===== sv/stream_pattern_replace_core_assert.svh =====
// Assertion macros shared by the stream pattern replace modules.
`ifndef STREAM_PATTERN_REPLACE_CORE_ASSERT_SVH
`define STREAM_PATTERN_REPLACE_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SPR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/spr_pkg.sv =====
// Package with types, constants and helpers for the stream pattern replace block.
`default_nettype none

package spr_pkg;

    // Width of the length registers and of all byte counts.
    localparam int LEN_W = 4;
    // Width of the configuration data bus and of the byte registers.
    localparam int DATA_W = 64;
    // Configuration address width: four registers on an 8-byte stride.
    localparam int ADDR_W = 5;

    // Default limits on pattern and replacement length.
    localparam int MAX_PATTERN_DEF     = 8;
    localparam int MAX_REPLACEMENT_DEF = 8;

    // Register indexes of the configuration port.
    typedef enum logic [1:0] {
        REG_PAT_LEN   = 2'd0,
        REG_PAT_BYTES = 2'd1,
        REG_REP_LEN   = 2'd2,
        REG_REP_BYTES = 2'd3
    } spr_reg_idx_t;

    // Effective configuration seen by the datapath.
    typedef struct packed {
        logic [LEN_W-1:0]  pat_len;
        logic [DATA_W-1:0] pat;
        logic [LEN_W-1:0]  rep_len;
        logic [DATA_W-1:0] rep;
    } spr_cfg_t;

    // Control of one load into the result serialiser.
    typedef struct packed {
        logic             load;
        logic [LEN_W-1:0] cnt;
        logic             last;
    } spr_ctl_t;

    // A zero length acts as one, a length above the limit acts as the limit.
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v,
                                                   input logic [LEN_W-1:0] maxv);
        logic [LEN_W-1:0] r;
        if (v == '0)
            r = LEN_W'(1);
        else if (v > maxv)
            r = maxv;
        else
            r = v;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/spr_regs.sv =====
// Configuration register file with its APB-style access port.
`default_nettype none

module spr_regs
    import spr_pkg::*;
#(
    parameter int MAX_PATTERN     = MAX_PATTERN_DEF,
    parameter int MAX_REPLACEMENT = MAX_REPLACEMENT_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output spr_cfg_t               cfg,
    output logic                   win_clear
);

    logic [LEN_W-1:0]  pat_len_reg;
    logic [DATA_W-1:0] pat_reg;
    logic [LEN_W-1:0]  rep_len_reg;
    logic [DATA_W-1:0] rep_reg;
    logic              wr_en;
    spr_reg_idx_t      idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = spr_reg_idx_t'(paddr[ADDR_W-1:3]);

    // Register writes on the access cycle of a write transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_len_reg <= LEN_W'(1);
            pat_reg     <= '0;
            rep_len_reg <= LEN_W'(1);
            rep_reg     <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_PAT_LEN:   pat_len_reg <= pwdata[LEN_W-1:0];
                REG_PAT_BYTES: pat_reg     <= pwdata;
                REG_REP_LEN:   rep_len_reg <= pwdata[LEN_W-1:0];
                REG_REP_BYTES: rep_reg     <= pwdata;
            endcase
        end
    end

    // A new pattern length drops whatever the window holds.
    assign win_clear = wr_en && (idx == REG_PAT_LEN);

    // Read-back of the stored values.
    always_comb
    begin
        unique case (idx)
            REG_PAT_LEN:   prdata = DATA_W'(pat_len_reg);
            REG_PAT_BYTES: prdata = pat_reg;
            REG_REP_LEN:   prdata = DATA_W'(rep_len_reg);
            REG_REP_BYTES: prdata = rep_reg;
        endcase
    end

    // Lengths as the datapath uses them.
    always_comb
    begin
        cfg.pat_len = clamp_len(pat_len_reg, LEN_W'(MAX_PATTERN));
        cfg.pat     = pat_reg;
        cfg.rep_len = clamp_len(rep_len_reg, LEN_W'(MAX_REPLACEMENT));
        cfg.rep     = rep_reg;
    end

endmodule

`default_nettype wire

// ===== sv/spr_window.sv =====
// Input register, lookahead window and per-byte match decision.
`default_nettype none
`include "stream_pattern_replace_core_assert.svh"

module spr_window
    import spr_pkg::*;
#(
    parameter int MAX_PATTERN     = MAX_PATTERN_DEF,
    parameter int MAX_REPLACEMENT = MAX_REPLACEMENT_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    input  wire logic        in_last,
    input  wire spr_cfg_t    cfg,
    input  wire logic        win_clear,
    input  wire logic        burst_free,
    output spr_ctl_t         ctl,
    output logic [((MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT)*8-1:0]
                             res_bytes
);

    localparam int WD = MAX_PATTERN;
    localparam int BD = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_last_reg;
    logic [7:0]       win_reg [WD];
    logic [7:0]       win_next [WD];
    logic [LEN_W-1:0] fill_reg;
    logic [LEN_W-1:0] fill_next;

    logic [7:0]       w [WD];
    logic [LEN_W-1:0] fill_c;
    logic [LEN_W-1:0] new_fill;
    logic [WD-1:0]    lane_ok;
    logic             full;
    logic             hit;
    logic             pop;
    logic             load;
    logic             accept;

    // The input register is passed on as soon as the serialiser can take its results.
    assign load     = in_valid_reg && burst_free;
    assign in_stall = in_valid_reg && !burst_free;
    assign accept   = in_valid && !in_stall;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (load)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= in_byte;
            in_last_reg <= in_last;
        end
    end

    // Place the new byte behind the bytes already held.
    always_comb
    begin
        fill_c = (fill_reg >= LEN_W'(WD)) ? LEN_W'(WD - 1) : fill_reg;
        for (int i = 0; i < WD; i++)
        begin
            w[i] = (LEN_W'(i) == fill_c) ? in_byte_reg : win_reg[i];
        end
        new_fill = fill_c + LEN_W'(1);
    end

    // Parallel compare of every window lane against the pattern.
    always_comb
    begin
        for (int i = 0; i < WD; i++)
        begin
            lane_ok[i] = (LEN_W'(i) >= cfg.pat_len) || (w[i] == cfg.pat[8*i +: 8]);
        end
        full = (new_fill >= cfg.pat_len);
        hit  = full && (&lane_ok);
        pop  = full && !hit;
    end

    // Result bytes: the replacement on a match, otherwise the window in order.
    genvar g;
    generate
        for (g = 0; g < BD; g++)
        begin : g_res
            if (g < WD)
            begin : g_win
                assign res_bytes[8*g +: 8] = hit ? cfg.rep[8*g +: 8] : w[g];
            end
            else
            begin : g_rep
                assign res_bytes[8*g +: 8] = hit ? cfg.rep[8*g +: 8] : 8'h00;
            end
        end
    endgenerate

    // Result count and next window state.
    always_comb
    begin
        ctl.load = load;
        ctl.last = in_last_reg;
        priority if (hit)
            ctl.cnt = cfg.rep_len;
        else if (in_last_reg)
            ctl.cnt = new_fill;
        else if (full)
            ctl.cnt = LEN_W'(1);
        else
            ctl.cnt = '0;

        win_next = w;
        if (pop)
        begin
            for (int i = 0; i < WD - 1; i++)
            begin
                win_next[i] = w[i + 1];
            end
        end

        priority if (hit || in_last_reg)
            fill_next = '0;
        else if (pop)
            fill_next = new_fill - LEN_W'(1);
        else
            fill_next = new_fill;
    end

    // Window fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (win_clear)
        begin
            fill_reg <= '0;
        end
        else if (load)
        begin
            fill_reg <= fill_next;
        end
    end

    // Window bytes; only entries below the fill count are ever used.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            win_reg <= win_next;
        end
    end

    `SPR_ASSERT_NOW(a_fill_below_len, 1'b1, fill_reg < cfg.pat_len, "window fill reached the pattern length")
    `SPR_ASSERT_NEXT(a_last_empties, load && in_last_reg, fill_reg == '0, "window not empty after the final byte")

endmodule

`default_nettype wire

// ===== sv/spr_burst.sv =====
// Result serialiser that hands out the bytes of one step, one per cycle while the output is not stalled.
`default_nettype none
`include "stream_pattern_replace_core_assert.svh"

module spr_burst
    import spr_pkg::*;
#(
    parameter int BURST_DEPTH = MAX_PATTERN_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire spr_ctl_t                 ctl,
    input  wire logic [BURST_DEPTH*8-1:0] res_bytes,
    output logic                          burst_free,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [7:0]                    out_byte,
    output logic                          run_last,
    output logic                          stream_end
);

    localparam int IW = (BURST_DEPTH > 1) ? $clog2(BURST_DEPTH) : 1;

    logic [BURST_DEPTH*8-1:0] bytes_reg;
    logic [IW-1:0]            idx_reg;
    logic [IW-1:0]            cnt_m1_reg;
    logic                     last_reg;
    logic                     valid_reg;
    logic                     take;
    logic                     final_byte;
    logic [LEN_W-1:0]         cnt_m1;

    assign final_byte = (idx_reg == cnt_m1_reg);
    assign take       = valid_reg && !out_stall;
    assign burst_free = !valid_reg || (take && final_byte);
    assign cnt_m1     = ctl.cnt - LEN_W'(1);

    // Burst control: a load with no results leaves the serialiser empty.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (ctl.load)
        begin
            valid_reg <= (ctl.cnt != '0);
            idx_reg   <= '0;
        end
        else if (take)
        begin
            if (final_byte)
                valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + IW'(1);
        end
    end

    // Burst payload.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            bytes_reg  <= res_bytes;
            cnt_m1_reg <= cnt_m1[IW-1:0];
            last_reg   <= ctl.last;
        end
    end

    // Current byte of the burst.
    always_comb
    begin
        out_byte = 8'h00;
        for (int i = 0; i < BURST_DEPTH; i++)
        begin
            if (idx_reg == IW'(i))
                out_byte = bytes_reg[8*i +: 8];
        end
    end

    assign out_valid  = valid_reg;
    assign run_last   = final_byte;
    assign stream_end = final_byte && last_reg;

    `SPR_ASSERT_NOW(a_idx_in_range, valid_reg, idx_reg <= cnt_m1_reg, "burst index beyond its count")
    `SPR_ASSERT_NEXT(a_burst_holds, take && !final_byte, valid_reg && (idx_reg == $past(idx_reg) + IW'(1)), "burst lost before its final byte")

endmodule

`default_nettype wire

// ===== sv/stream_pattern_replace_core.sv =====
// Top level of the stream pattern replace block.
// Byte-stream search and replace: each non-overlapping occurrence of the
// configured pattern, leftmost first, is replaced by the configured
// replacement and other bytes pass through. One byte is taken per cycle while
// each byte yields at most one result and the output is not stalled; a byte
// that completes a match or ends the stream yields up to the larger of
// MAX_PATTERN and MAX_REPLACEMENT results, which leave through the result
// serialiser one per cycle while the output is not stalled. A byte's first
// result leaves after the input register and then the serialiser. While a
// burst waits at the output the input register can still take one byte;
// further bytes are stalled until the final byte of the burst has been accepted.
`default_nettype none

module stream_pattern_replace_core
    import spr_pkg::*;
#(
    parameter int MAX_PATTERN     = MAX_PATTERN_DEF,
    parameter int MAX_REPLACEMENT = MAX_REPLACEMENT_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [7:0]        in_byte,
    input  wire logic              in_last,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [7:0]             out_byte,
    output logic                   run_last,
    output logic                   stream_end,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    localparam int BD = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;

    spr_cfg_t        cfg;
    spr_ctl_t        ctl;
    logic            win_clear;
    logic            burst_free;
    logic [BD*8-1:0] res_bytes;

    // Configuration registers.
    spr_regs #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT)
    ) u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cfg       (cfg),
        .win_clear (win_clear)
    );

    // Window and match decision.
    spr_window #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .cfg        (cfg),
        .win_clear  (win_clear),
        .burst_free (burst_free),
        .ctl        (ctl),
        .res_bytes  (res_bytes)
    );

    // Result serialiser.
    spr_burst #(
        .BURST_DEPTH (BD)
    ) u_burst (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .res_bytes  (res_bytes),
        .burst_free (burst_free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .stream_end (stream_end)
    );

endmodule

`default_nettype wire
